@@ src/rsp_pkg.sv @@
package rsp_pkg;

	localparam int MAX_RECORDS = 64;
	localparam int NAME_CHARS  = 8;

	localparam int PRICE_W = 32;
	localparam int NAME_W  = 64;
	localparam int TAG_W   = 8;

	typedef struct packed {
		logic               vld;
		logic [PRICE_W-1:0] price;
		logic [NAME_W-1:0]  name;
		logic [NAME_W-1:0]  key;
		logic [TAG_W-1:0]   tag;
	} rec_t;

	typedef struct packed {
		logic ins;
		logic pop;
	} ctl_t;

	// strcmp view of a name: first NAME_CHARS bytes, zero after the first NUL
	function automatic logic [NAME_W-1:0] name_key(logic [NAME_W-1:0] n);
		logic [NAME_W-1:0] k;
		logic              stop;
		k    = '0;
		stop = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (i < NAME_CHARS && !stop && n[NAME_W-1-8*i -: 8] != 8'd0) begin
				k[NAME_W-1-8*i -: 8] = n[NAME_W-1-8*i -: 8];
			end else begin
				stop = 1'b1;
			end
		end
		return k;
	endfunction

endpackage

@@ src/rsp_if.sv @@
interface rsp_load_if;
	logic                         valid;
	logic                         ready;
	logic [rsp_pkg::PRICE_W-1:0]  price;
	logic [rsp_pkg::NAME_W-1:0]   name_bytes;
	logic [rsp_pkg::TAG_W-1:0]    tag;
	logic                         last_in;

	modport source (output valid, price, name_bytes, tag, last_in, input ready);
	modport sink   (input valid, price, name_bytes, tag, last_in, output ready);
endinterface

interface rsp_emit_if;
	logic                         valid;
	logic                         ready;
	logic [rsp_pkg::PRICE_W-1:0]  out_price;
	logic [rsp_pkg::NAME_W-1:0]   out_name;
	logic [rsp_pkg::TAG_W-1:0]    out_tag;
	logic                         out_last;

	modport source (output valid, out_price, out_name, out_tag, out_last, input ready);
	modport sink   (input valid, out_price, out_name, out_tag, out_last, output ready);
endinterface

@@ src/rsp_cell.sv @@
module rsp_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  rsp_pkg::ctl_t ctl,
	input  rsp_pkg::rec_t nrec,
	input  rsp_pkg::rec_t left_rec,
	input  logic          left_gt,
	input  rsp_pkg::rec_t right_rec,
	output rsp_pkg::rec_t cur,
	output logic          gt
);

	rsp_pkg::rec_t rec_q;
	rsp_pkg::rec_t rec_d;
	logic          load_en;

	// empty cells sort after everything; equal keys keep arrival order
	assign gt = !rec_q.vld || ({rec_q.price, rec_q.key} > {nrec.price, nrec.key});

	always_comb begin
		rec_d   = rec_q;
		load_en = 1'b0;
		if (ctl.pop) begin
			rec_d   = right_rec;
			load_en = 1'b1;
		end else if (ctl.ins && gt) begin
			rec_d   = left_gt ? left_rec : nrec;
			load_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (load_en) begin
			rec_q <= rec_d;
		end
	end

	assign cur = rec_q;

endmodule

@@ src/record_sort_price_then_name_core.sv @@
// Stable sorter for record sets keyed by price, then name.
// load: one word per record (price, name_bytes, tag, last_in). Records enter
// a chain of MAX_RECORDS cells at one per cycle while load.ready is high;
// each new word is compared against every cell and slots into place in the
// same cycle, so the chain is always sorted. Records past MAX_RECORDS in one
// set are dropped. A word with last_in set ends the set. In the next cycle
// emit starts presenting the sorted set from the head cell, one word per
// cycle while emit.ready is high; out_last marks the final word.
// load.ready is low while a set is draining. If emit.ready is low, the head
// word holds and the chain stays put.
// Reset empties the chain and returns to loading.
module record_sort_price_then_name_core #(
	parameter int MAX_RECORDS = rsp_pkg::MAX_RECORDS
) (
	input  logic       clk,
	input  logic       arst_n,
	rsp_load_if.sink   load,
	rsp_emit_if.source emit
);

	rsp_pkg::rec_t cells [MAX_RECORDS];
	logic          gts   [MAX_RECORDS];
	rsp_pkg::rec_t nrec;
	rsp_pkg::ctl_t ctl;
	logic          drain_q;
	logic          load_acc;
	logic          full;

	assign full        = cells[MAX_RECORDS-1].vld;
	assign load.ready  = !drain_q;
	assign load_acc    = load.valid && load.ready;

	assign nrec.vld    = 1'b1;
	assign nrec.price  = load.price;
	assign nrec.name   = load.name_bytes;
	assign nrec.key    = rsp_pkg::name_key(load.name_bytes);
	assign nrec.tag    = load.tag;

	assign ctl.ins     = load_acc && !full;
	assign ctl.pop     = drain_q && emit.ready;

	generate
		for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
			rsp_pkg::rec_t left_rec;
			rsp_pkg::rec_t right_rec;
			logic          left_gt;
			if (i == 0) begin : g_head
				assign left_rec = '0;
				assign left_gt  = 1'b0;
			end else begin : g_mid
				assign left_rec = cells[i-1];
				assign left_gt  = gts[i-1];
			end
			if (i == MAX_RECORDS - 1) begin : g_tail
				assign right_rec = '0;
			end else begin : g_body
				assign right_rec = cells[i+1];
			end
			rsp_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.nrec      (nrec),
				.left_rec  (left_rec),
				.left_gt   (left_gt),
				.right_rec (right_rec),
				.cur       (cells[i]),
				.gt        (gts[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
		end else if (load_acc && load.last_in) begin
			drain_q <= 1'b1;
		end else if (ctl.pop && emit.out_last) begin
			drain_q <= 1'b0;
		end
	end

	assign emit.valid     = drain_q;
	assign emit.out_price = cells[0].price;
	assign emit.out_name  = cells[0].name;
	assign emit.out_tag   = cells[0].tag;
	assign emit.out_last  = !cells[1].vld;

endmodule

@@ src/rsp_chk.sv @@
module rsp_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        load_valid,
	input logic                        load_ready,
	input logic                        load_last,
	input logic                        emit_valid,
	input logic                        emit_ready,
	input logic                        emit_last,
	input logic [rsp_pkg::PRICE_W-1:0] emit_price,
	input logic [rsp_pkg::NAME_W-1:0]  emit_name
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(load_ready && emit_valid))
		else $error("load open while draining");

	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		load_valid && load_ready && load_last |=> emit_valid)
		else $error("no output after end of set");

	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid && emit_ready && emit_last |=> !emit_valid && load_ready)
		else $error("drain did not end after final word");

	a_drain_cont: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid && emit_ready && !emit_last |=> emit_valid)
		else $error("drain stopped early");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid && !emit_ready |=> emit_valid && $stable(emit_price) && $stable(emit_name))
		else $error("stalled word changed");

endmodule

bind record_sort_price_then_name_core rsp_chk u_rsp_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.load_valid (load.valid),
	.load_ready (load.ready),
	.load_last  (load.last_in),
	.emit_valid (emit.valid),
	.emit_ready (emit.ready),
	.emit_last  (emit.out_last),
	.emit_price (emit.out_price),
	.emit_name  (emit.out_name)
);

@@ tb/record_sort_price_then_name_core_tb.sv @@
`timescale 1ns / 1ps

module record_sort_price_then_name_core_tb;

	localparam int CLK_HALF    = 4;
	localparam int RST_CYC     = 12;
	localparam int HOLD_CYC    = 180;
	localparam int DRAIN_CYC   = 16;
	localparam int PHASE_ITEMS = 22;
	localparam int FULL_SET    = rsp_pkg::MAX_RECORDS + 2;
	localparam int MAX_PRINTS  = 40;
	localparam longint TIMEOUT_NS = 64'd8 * 64'd300000;

	typedef struct packed {
		logic [rsp_pkg::PRICE_W-1:0] price;
		logic [rsp_pkg::NAME_W-1:0]  name;
		logic [rsp_pkg::TAG_W-1:0]   tag;
		logic                        fin;
	} sorted_word_t;

	typedef struct packed {
		sorted_word_t rec;
		logic         typed;
		sorted_word_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	rsp_load_if load_bus ();
	rsp_emit_if emit_bus ();

	record_sort_price_then_name_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load_bus),
		.emit   (emit_bus)
	);

	sorted_word_t sorted_due[$];
	sorted_word_t held_recs[rsp_pkg::MAX_RECORDS];
	int           held_cnt;
	sorted_word_t due_word;
	dir_row_t     dir_rows[17];

	int  mismatch_cnt;
	int  words_loaded;
	int  words_checked;
	int  sets_closed;
	int  idle_pct;
	int  stall_pct;
	bit  hold_armed;
	int  hold_left;

	always begin
		clk = 1'b1;
		#CLK_HALF;
		clk = 1'b0;
		#CLK_HALF;
	end

	initial begin
		#TIMEOUT_NS;
		$display("timeout: %0d words still due", sorted_due.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// strcmp view: first NAME_CHARS bytes, nothing past the first NUL
	function automatic logic [rsp_pkg::NAME_W-1:0] strcmp_view(
			logic [rsp_pkg::NAME_W-1:0] n);
		logic [rsp_pkg::NAME_W-1:0] k;
		bit                         done;
		k    = '0;
		done = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (i >= rsp_pkg::NAME_CHARS || n[rsp_pkg::NAME_W-1-8*i -: 8] == 8'h00)
				done = 1'b1;
			if (!done)
				k[rsp_pkg::NAME_W-1-8*i -: 8] = n[rsp_pkg::NAME_W-1-8*i -: 8];
		end
		return k;
	endfunction

	function automatic bit ranks_after(sorted_word_t a, sorted_word_t b);
		if (a.price != b.price)
			return a.price > b.price;
		return strcmp_view(a.name) > strcmp_view(b.name);
	endfunction

	task automatic book_record(input sorted_word_t r, input bit emit_due);
		int           pos;
		sorted_word_t w;
		if (held_cnt < rsp_pkg::MAX_RECORDS) begin
			pos = held_cnt;
			while (pos > 0 && ranks_after(held_recs[pos-1], r)) begin
				held_recs[pos] = held_recs[pos-1];
				pos--;
			end
			held_recs[pos] = r;
			held_cnt++;
		end
		if (r.fin) begin
			for (int i = 0; i < held_cnt; i++) begin
				w     = held_recs[i];
				w.fin = (i == held_cnt - 1);
				if (emit_due)
					sorted_due.push_back(w);
			end
			held_cnt = 0;
			sets_closed++;
		end
	endtask

	task automatic note_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_PRINTS)
			$display("mismatch %s: got %h want %h at %0t ns", what, got, want, $realtime);
	endtask

	task automatic offer_word(input sorted_word_t w, input bit typed, input sorted_word_t want);
		while ($urandom_range(0, 99) < idle_pct) begin
			load_bus.valid <= 1'b0;
			@(posedge clk);
		end
		load_bus.valid      <= 1'b1;
		load_bus.price      <= w.price;
		load_bus.name_bytes <= w.name;
		load_bus.tag        <= w.tag;
		load_bus.last_in    <= w.fin;
		@(posedge clk);
		while (!load_bus.ready)
			@(posedge clk);
		book_record(w, !typed);
		if (typed)
			sorted_due.push_back(want);
		words_loaded++;
	endtask

	function automatic logic [rsp_pkg::NAME_W-1:0] rand_name();
		logic [rsp_pkg::NAME_W-1:0] n;
		int                         len;
		int                         style;
		bit                         junk;
		n     = '0;
		style = $urandom_range(0, 3);
		len   = $urandom_range(0, 8);
		junk  = 1'($urandom_range(0, 1));
		if (style == 0)
			return {$urandom, $urandom};
		for (int i = 0; i < 8; i++) begin
			if (i < len) begin
				if (style == 1)
					n[rsp_pkg::NAME_W-1-8*i -: 8] = 8'($urandom_range(1, 255));
				else
					n[rsp_pkg::NAME_W-1-8*i -: 8] = 8'($urandom_range(8'h41, 8'h43));
			end else if (i > len && junk) begin
				n[rsp_pkg::NAME_W-1-8*i -: 8] = 8'($urandom_range(0, 255));
			end
		end
		return n;
	endfunction

	function automatic sorted_word_t rand_record();
		sorted_word_t r;
		case ($urandom_range(0, 3))
			0: r.price = $urandom;
			1, 2: r.price = $urandom_range(0, 5);
			default: begin
				case ($urandom_range(0, 2))
					0: r.price = 32'h0000_0000;
					1: r.price = 32'h8000_0000;
					default: r.price = 32'hFFFF_FFFF;
				endcase
			end
		endcase
		r.name = rand_name();
		r.tag  = 8'($urandom_range(0, 255));
		r.fin  = 1'b0;
		return r;
	endfunction

	task automatic run_set(input int n, input bit hold_on_last);
		sorted_word_t r;
		for (int i = 0; i < n; i++) begin
			r     = rand_record();
			r.fin = (i == n - 1);
			if (r.fin && hold_on_last)
				hold_armed = 1'b1;
			offer_word(r, 1'b0, '0);
		end
	endtask

	task automatic run_phase(input int idle, input int stall);
		int sent;
		int n;
		idle_pct  = idle;
		stall_pct = stall;
		sent      = 0;
		while (sent < PHASE_ITEMS) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
			run_set(n, 1'b0);
			sent += n;
		end
	endtask

	// output side: random stalls, plus one long hold on request
	initial begin
		emit_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_armed) begin
				hold_left  = HOLD_CYC;
				hold_armed = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				emit_bus.ready <= 1'b0;
			end else begin
				emit_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && emit_bus.valid && emit_bus.ready) begin
			words_checked++;
			if (sorted_due.size() == 0) begin
				note_mismatch("word with nothing due, price", 64'(emit_bus.out_price), '0);
			end else begin
				due_word = sorted_due.pop_front();
				if (emit_bus.out_price !== due_word.price)
					note_mismatch("out_price", 64'(emit_bus.out_price),
						64'(due_word.price));
				if (emit_bus.out_name !== due_word.name)
					note_mismatch("out_name", emit_bus.out_name, due_word.name);
				if (emit_bus.out_tag !== due_word.tag)
					note_mismatch("out_tag", 64'(emit_bus.out_tag), 64'(due_word.tag));
				if (emit_bus.out_last !== due_word.fin)
					note_mismatch("out_last", 64'(emit_bus.out_last), 64'(due_word.fin));
			end
		end
	end

	initial begin
		arst_n              = 1'b0;
		load_bus.valid      = 1'b0;
		load_bus.price      = '0;
		load_bus.name_bytes = '0;
		load_bus.tag        = '0;
		load_bus.last_in    = 1'b0;
		mismatch_cnt        = 0;
		words_loaded        = 0;
		words_checked       = 0;
		sets_closed         = 0;
		held_cnt            = 0;
		idle_pct            = 0;
		stall_pct           = 0;
		hold_armed          = 1'b0;
		hold_left           = 0;

		// single-word sets are typed in; the rest go through the predictor
		dir_rows = '{
			'{'{32'h0000_0000, 64'h0000_0000_0000_0000, 8'h00, 1'b1}, 1'b1,
				'{32'h0000_0000, 64'h0000_0000_0000_0000, 8'h00, 1'b1}},
			'{'{32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1}, 1'b1,
				'{32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1}},
			'{'{32'h8000_0000, 64'h4142_4300_0000_0000, 8'h5A, 1'b1}, 1'b1,
				'{32'h8000_0000, 64'h4142_4300_0000_0000, 8'h5A, 1'b1}},
			'{'{32'd10, 64'h424F_4200_0000_0000, 8'd1,  1'b0}, 1'b0, '0},
			'{'{32'd5,  64'h5A45_4400_0000_0000, 8'd2,  1'b0}, 1'b0, '0},
			'{'{32'd10, 64'h414C_4943_4500_0000, 8'd3,  1'b0}, 1'b0, '0},
			'{'{32'd10, 64'h4142_0058_0000_0000, 8'd4,  1'b0}, 1'b0, '0},
			'{'{32'd10, 64'h4142_0059_0000_0000, 8'd5,  1'b0}, 1'b0, '0},
			'{'{32'd10, 64'h8000_0000_0000_0000, 8'd6,  1'b0}, 1'b0, '0},
			'{'{32'd10, 64'h4142_0000_0000_0000, 8'd7,  1'b0}, 1'b0, '0},
			'{'{32'd5,  64'h5A45_4400_0000_0000, 8'd8,  1'b0}, 1'b0, '0},
			'{'{32'd10, 64'h4142_4344_4546_4748, 8'd11, 1'b0}, 1'b0, '0},
			'{'{32'd10, 64'h4142_4344_4546_4747, 8'd12, 1'b0}, 1'b0, '0},
			'{'{32'd10, 64'h0000_0000_0000_0000, 8'd13, 1'b0}, 1'b0, '0},
			'{'{32'd10, 64'h0058_5900_0000_0000, 8'd14, 1'b0}, 1'b0, '0},
			'{'{32'hFFFF_FFFF, 64'h0000_0000_0000_0000, 8'd9, 1'b0}, 1'b0, '0},
			'{'{32'd0,  64'hFFFF_FFFF_FFFF_FFFF, 8'd10, 1'b1}, 1'b0, '0}
		};

		repeat (RST_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			offer_word(dir_rows[i].rec, dir_rows[i].typed, dir_rows[i].want);

		// overfull set: last two words are dropped, the last one still closes the set;
		// the output then holds off while the next set waits at the input
		run_set(FULL_SET, 1'b1);

		run_phase(0, 0);
		run_phase(73, 0);
		run_phase(0, 73);
		run_phase(11, 11);

		load_bus.valid <= 1'b0;
		while (sorted_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("loaded %0d words in %0d sets, checked %0d sorted words",
			words_loaded, sets_closed, words_checked);
		$display("pacing: free-running, input gaps, output stalls, mixed, one long output hold");
		if (mismatch_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", mismatch_cnt);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
